>>> rtl/core/hee_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character tables for the HTML entity escaper.
// Depends on nothing; used by every module of the block.
package hee_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_QUOT,
		KIND_AMP,
		KIND_APOS,
		KIND_LT,
		KIND_GT,
		KIND_NUM
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] ch;
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} entry_t;

	localparam logic [6:0] CH_AMP  = 7'h26;
	localparam logic [6:0] CH_HASH = 7'h23;
	localparam logic [6:0] CH_SEMI = 7'h3b;
	localparam logic [6:0] CH_ZERO = 7'h30;

	function automatic logic [2:0] run_len(kind_t kind);
		case (kind)
			KIND_PASS: run_len = 3'd1;
			KIND_QUOT: run_len = 3'd6;
			KIND_AMP:  run_len = 3'd5;
			KIND_APOS: run_len = 3'd5;
			KIND_LT:   run_len = 3'd4;
			KIND_GT:   run_len = 3'd4;
			KIND_NUM:  run_len = 3'd6;
			default:   run_len = 3'd1;
		endcase
	endfunction

	function automatic logic [6:0] char_at(entry_t e, logic [2:0] idx);
		logic [6:0] c;
		c = CH_SEMI;
		if (idx == 3'd0) begin
			c = CH_AMP;
		end
		case (e.kind)
			KIND_PASS: c = e.ch;
			KIND_QUOT: begin
				case (idx)
					3'd1: c = 7'h71;
					3'd2: c = 7'h75;
					3'd3: c = 7'h6f;
					3'd4: c = 7'h74;
					default: ;
				endcase
			end
			KIND_AMP: begin
				case (idx)
					3'd1: c = 7'h61;
					3'd2: c = 7'h6d;
					3'd3: c = 7'h70;
					default: ;
				endcase
			end
			KIND_APOS: begin
				case (idx)
					3'd1: c = CH_HASH;
					3'd2: c = 7'h33;
					3'd3: c = 7'h39;
					default: ;
				endcase
			end
			KIND_LT: begin
				case (idx)
					3'd1: c = 7'h6c;
					3'd2: c = 7'h74;
					default: ;
				endcase
			end
			KIND_GT: begin
				case (idx)
					3'd1: c = 7'h67;
					3'd2: c = 7'h74;
					default: ;
				endcase
			end
			KIND_NUM: begin
				case (idx)
					3'd1: c = CH_HASH;
					3'd2: c = CH_ZERO | {5'd0, e.hund};
					3'd3: c = CH_ZERO | {3'd0, e.tens};
					3'd4: c = CH_ZERO | {3'd0, e.ones};
					default: ;
				endcase
			end
			default: ;
		endcase
		char_at = c;
	endfunction

endpackage

>>> rtl/core/hee_front.sv
`timescale 1ns / 1ps
// Front end: accepts text bytes, classifies them and splits high bytes into digits.
// Depends on hee_pkg; feeds hee_queue.
module hee_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        text_byte,
	input  logic              q_full,
	output logic              q_push,
	output hee_pkg::entry_t   q_entry
);

	logic        high;
	logic [7:0]  rem8;
	logic [6:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  tens10;
	logic [6:0]  ones7;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && (text_byte != 8'd0);

	// Bytes from 127 up always have a hundreds digit of one or two.
	assign high   = (text_byte >= 8'd200);
	assign rem8   = text_byte - (high ? 8'd200 : 8'd100);
	assign rem    = rem8[6:0];
	assign prod   = {8'd0, rem} * 15'd205;
	assign tens   = prod[14:11];
	assign tens10 = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
	assign ones7  = rem - tens10;

	always_comb begin
		q_entry.ch   = text_byte[6:0];
		q_entry.hund = high ? 2'd2 : 2'd1;
		q_entry.tens = tens;
		q_entry.ones = ones7[3:0];
		if (text_byte[7] || text_byte[6:0] == 7'h7f) begin
			q_entry.kind = hee_pkg::KIND_NUM;
		end else begin
			case (text_byte[6:0])
				7'h22:   q_entry.kind = hee_pkg::KIND_QUOT;
				7'h26:   q_entry.kind = hee_pkg::KIND_AMP;
				7'h27:   q_entry.kind = hee_pkg::KIND_APOS;
				7'h3c:   q_entry.kind = hee_pkg::KIND_LT;
				7'h3e:   q_entry.kind = hee_pkg::KIND_GT;
				default: q_entry.kind = hee_pkg::KIND_PASS;
			endcase
		end
	end

endmodule

>>> rtl/core/hee_queue.sv
`timescale 1ns / 1ps
// Short queue of classified entries between the front and back ends.
// Depends on hee_pkg.
module hee_queue #(
	parameter int DEPTH = hee_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hee_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hee_pkg::entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hee_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/hee_back.sv
`timescale 1ns / 1ps
// Back end: walks each queued entry one character per cycle, while out_stall allows, into the output register.
// Depends on hee_pkg; reads the head of hee_queue.
module hee_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  hee_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [6:0]      out_char,
	output logic            is_last
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       is_last_q;
	logic       take;
	logic       last;

	assign take = head_valid && (!out_valid_q || !out_stall);
	assign last = (idx_q == hee_pkg::run_len(head_entry.kind) - 3'd1);
	assign pop  = take && last;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = is_last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= hee_pkg::char_at(head_entry, idx_q);
			is_last_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/html_entity_escaper_top.sv
`timescale 1ns / 1ps
// HTML entity escaper: one text byte in, its escaped character run out.
// The first character of a byte passes through the queue and then the output register.
// Output: one character per cycle while out_stall is low, from the back end's character
// sequencer; a byte gives 1, 4, 5 or 6 characters, a zero byte gives none.
// Reset: arst_n empties the queue and the output register at once.
module html_entity_escaper_top #(
	parameter int QUEUE_DEPTH = hee_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       is_last
);

	logic            q_full;
	logic            q_push;
	hee_pkg::entry_t q_entry;
	logic            q_pop;
	logic            head_valid;
	hee_pkg::entry_t head_entry;

	hee_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_byte (text_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	hee_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.is_last    (is_last)
	);

endmodule

>>> verif/html_entity_escaper_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for html_entity_escaper_top: directed and random bytes, with
// random idling on both channels, checked character by character against an inline predictor.
// Depends on the RTL of html_entity_escaper_top and the modules and package beneath it.
module html_entity_escaper_top_tb;

	localparam logic [7:0] BYTE_TERM  = 8'h00;
	localparam logic [7:0] BYTE_QUOT  = 8'h22;
	localparam logic [7:0] BYTE_AMP   = 8'h26;
	localparam logic [7:0] BYTE_APOS  = 8'h27;
	localparam logic [7:0] BYTE_LT    = 8'h3c;
	localparam logic [7:0] BYTE_GT    = 8'h3e;
	localparam logic [7:0] HIGH_START = 8'h7f;
	localparam int RANDOM_BYTES = 136;
	localparam int CALM_TAIL    = 30;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} esc_char_t;

	typedef struct {
		logic [7:0] text;
		bit         drain;
	} pending_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] out_char;
	logic       is_last;

	pending_byte_t pending_bytes[$];
	esc_char_t     expected_chars[$];
	int            send_gap;
	int            stall_left;
	int            hold_left;
	bit            hold_done;
	bit            hold_active;
	int            accepted_bytes;
	int            terminators;
	int            chars_checked;
	int            mismatches;

	html_entity_escaper_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_byte (text_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.is_last   (is_last)
	);

	function automatic void push_run(string s);
		byte c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			expected_chars.push_back('{ch: c[6:0], last: (i == s.len() - 1)});
		end
	endfunction

	function automatic void predict_escape(logic [7:0] b);
		if (b == BYTE_TERM) begin
			return;
		end
		case (b)
			BYTE_QUOT: push_run("&quot;");
			BYTE_AMP:  push_run("&amp;");
			BYTE_APOS: push_run("&#39;");
			BYTE_LT:   push_run("&lt;");
			BYTE_GT:   push_run("&gt;");
			default: begin
				if (b >= HIGH_START) begin
					push_run($sformatf("&#%0d;", b));
				end else begin
					expected_chars.push_back('{ch: b[6:0], last: 1'b1});
				end
			end
		endcase
	endfunction

	function automatic void add_byte(logic [7:0] b, bit drain);
		pending_bytes.push_back('{text: b, drain: drain});
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Sender: holds a stalled transfer, otherwise idles in random bursts, waits for a drain, or presents the next byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= BYTE_TERM;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_escape(text_byte);
				accepted_bytes++;
				if (text_byte == BYTE_TERM) begin
					terminators++;
				end
			end
			if (in_valid && in_stall) begin
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_bytes[0].drain && expected_chars.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending_bytes.size() >= CALM_TAIL && !hold_active &&
					$urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				send_gap = $urandom_range(1, 16) - 1;
			end else begin
				in_valid <= 1'b1;
				text_byte <= pending_bytes[0].text;
				pending_bytes.pop_front();
			end
		end
	end

	// Receiver: one long hold-off once, and random stall bursts until the tail of the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
			hold_active = 1'b0;
		end else if (!hold_done && accepted_bytes >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_active = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) begin
				hold_active = 1'b0;
			end
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (pending_bytes.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		esc_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				if (mismatches < REPORT_MAX) begin
					$display("%t: unexpected character %h last %b", $realtime, out_char, is_last);
				end
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (out_char !== want.ch || is_last !== want.last) begin
					if (mismatches < REPORT_MAX) begin
						$display("%t: mismatch: expected char %h last %b, got char %h last %b",
							$realtime, want.ch, want.last, out_char, is_last);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		int nonzero;
		logic [7:0] b;
		add_byte(BYTE_TERM, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(BYTE_QUOT, 1'b0);
		add_byte(BYTE_AMP, 1'b0);
		add_byte(BYTE_APOS, 1'b0);
		add_byte(BYTE_LT, 1'b0);
		add_byte(BYTE_GT, 1'b0);
		add_byte(8'h7e, 1'b0);
		add_byte(HIGH_START, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(BYTE_TERM, 1'b0);
		add_byte(BYTE_TERM, 1'b0);
		add_byte(8'h41, 1'b1);
		add_byte(8'h23, 1'b0);
		add_byte(8'h3b, 1'b0);
		add_byte(8'h64, 1'b0);
		add_byte(8'hc8, 1'b0);
		add_byte(8'h99, 1'b0);
		nonzero = 0;
		while (nonzero < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: b = BYTE_TERM;
				1, 2, 3: begin
					case ($urandom_range(0, 4))
						0: b = BYTE_QUOT;
						1: b = BYTE_AMP;
						2: b = BYTE_APOS;
						3: b = BYTE_LT;
						default: b = BYTE_GT;
					endcase
				end
				4, 5: b = 8'($urandom_range(HIGH_START, 255));
				default: b = 8'($urandom_range(0, 255));
			endcase
			if (b != BYTE_TERM) begin
				nonzero++;
			end
			add_byte(b, nonzero == RANDOM_BYTES / 2);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (pending_bytes.size() != 0 || in_valid);
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Run covered %0d byte transfers (%0d terminators), %0d characters checked.",
			accepted_bytes, terminators, chars_checked);
		$display("Mismatches: %0d, characters still outstanding: %0d.",
			mismatches, expected_chars.size());
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("html_entity_escaper_top_tb: done, clean");
		end else begin
			$display("html_entity_escaper_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d characters outstanding.", expected_chars.size());
		$display("html_entity_escaper_top_tb: done, errors");
		$finish;
	end

endmodule

>>> html_entity_escaper_top.f
rtl/core/hee_pkg.sv
rtl/core/hee_front.sv
rtl/core/hee_queue.sv
rtl/core/hee_back.sv
rtl/core/html_entity_escaper_top.sv
verif/html_entity_escaper_top_tb.sv
